// ----- src/v2a_pkg.sv -----
// shared constants, operation codes and pipeline types for the 2d vector alu
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package v2a_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int FUNC_W    = 3;

	localparam logic [FUNC_W-1:0] FUNC_ADD   = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_SUB   = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_SCALE = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_LEN   = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_NORM  = 3'd4;

	// square root of the sum of squares
	localparam int SQ_W       = 2 * DATA_W;
	localparam int ROOT_W     = DATA_W;
	localparam int SQRT_STEPS = ROOT_W;
	localparam int SREM_W     = ROOT_W + 3;

	// normalize divider: quotient never exceeds one plus a little
	localparam int QUOT_W = FRAC_BITS + 2;
	localparam int DREM_W = DATA_W + QUOT_W;

	// item sideband carried alongside the sqrt and divide units
	localparam int META_DIV_IDX = SQRT_STEPS + 1;
	localparam int META_MAG_IDX = SQRT_STEPS + 2;
	localparam int META_LAST    = META_DIV_IDX + 1 + QUOT_W;
	localparam int META_DEPTH   = META_LAST + 1;

	typedef struct packed {
		logic [FUNC_W-1:0]        func;
		logic signed [DATA_W-1:0] res_x;
		logic signed [DATA_W-1:0] res_y;
		logic                     sat;
		logic                     neg_x;
		logic                     neg_y;
		logic [DATA_W-1:0]        ux;
		logic [DATA_W-1:0]        uy;
		logic [ROOT_W-1:0]        mag;
	} meta_t;

endpackage

`default_nettype wire

// ----- src/v2a_lane.sv -----
// one component lane: add/sub, scale multiply with rounding and saturation, square
// depends on v2a_pkg
`timescale 1ns / 1ps
`default_nettype none

module v2a_lane (
	input  wire logic                                  clk,
	input  wire logic                                  en,
	input  wire logic [v2a_pkg::FUNC_W-1:0]            func_s1,
	input  wire logic [v2a_pkg::FUNC_W-1:0]            func_s2,
	input  wire logic signed [v2a_pkg::DATA_W-1:0]     a,
	input  wire logic signed [v2a_pkg::DATA_W-1:0]     b,
	input  wire logic signed [v2a_pkg::DATA_W-1:0]     sf,
	output logic signed [v2a_pkg::DATA_W-1:0]          res,
	output logic                                       sat,
	output logic [v2a_pkg::SQ_W-1:0]                   sq,
	output logic                                       neg,
	output logic [v2a_pkg::DATA_W-1:0]                 ua
);

	localparam int W  = v2a_pkg::DATA_W;
	localparam int PW = 2 * W;

	logic signed [W-1:0]  mult;
	logic signed [PW-1:0] prod_s2;
	logic signed [W:0]    sum_s2;
	logic signed [W-1:0]  a_s2;
	logic signed [PW:0]   rnd_sum;
	logic signed [PW:0]   shifted;
	logic                 sc_hi, sc_lo, as_hi, as_lo;

	// squares reuse the scale multiplier
	assign mult = (func_s1 == v2a_pkg::FUNC_SCALE) ? sf : a;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= a * mult;
			if (func_s1 == v2a_pkg::FUNC_SUB) begin
				sum_s2 <= {a[W-1], a} - {b[W-1], b};
			end else begin
				sum_s2 <= {a[W-1], a} + {b[W-1], b};
			end
			a_s2 <= a;
		end
	end

	// round to nearest, ties up, then floor shift
	assign rnd_sum = {prod_s2[PW-1], prod_s2} + ((PW+1)'(1) << (v2a_pkg::FRAC_BITS - 1));
	assign shifted = rnd_sum >>> v2a_pkg::FRAC_BITS;
	assign sc_hi   = !shifted[PW] && (|shifted[PW-1:W-1]);
	assign sc_lo   = shifted[PW] && !(&shifted[PW-1:W-1]);
	assign as_hi   = !sum_s2[W] && sum_s2[W-1];
	assign as_lo   = sum_s2[W] && !sum_s2[W-1];

	always_comb begin
		res = '0;
		sat = 1'b0;
		case (func_s2)
			v2a_pkg::FUNC_ADD, v2a_pkg::FUNC_SUB: begin
				sat = as_hi | as_lo;
				if (as_hi) res = {1'b0, {(W-1){1'b1}}};
				else if (as_lo) res = {1'b1, {(W-1){1'b0}}};
				else res = sum_s2[W-1:0];
			end
			v2a_pkg::FUNC_SCALE: begin
				sat = sc_hi | sc_lo;
				if (sc_hi) res = {1'b0, {(W-1){1'b1}}};
				else if (sc_lo) res = {1'b1, {(W-1){1'b0}}};
				else res = shifted[W-1:0];
			end
			default: begin
				res = '0;
				sat = 1'b0;
			end
		endcase
	end

	assign sq  = prod_s2;
	assign neg = a_s2[W-1];
	assign ua  = neg ? (-a_s2) : a_s2;

endmodule

`default_nettype wire

// ----- src/v2a_sqrt.sv -----
// pipelined integer square root of the merged sum of squares, rounded to nearest
// depends on v2a_pkg
`timescale 1ns / 1ps
`default_nettype none

module v2a_sqrt (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [v2a_pkg::SQ_W-1:0]      sq_x,
	input  wire logic [v2a_pkg::SQ_W-1:0]      sq_y,
	output logic [v2a_pkg::ROOT_W-1:0]         mag
);

	localparam int SW = v2a_pkg::SQ_W;
	localparam int RW = v2a_pkg::ROOT_W;
	localparam int MW = v2a_pkg::SREM_W;
	localparam int N  = v2a_pkg::SQRT_STEPS;

	logic [SW-1:0] rad_q  [0:N];
	logic [MW-1:0] rem_q  [0:N];
	logic [RW-1:0] root_q [0:N];
	logic [RW-1:0] mag_q;

	// merge the two lanes
	always_ff @(posedge clk) begin
		if (en) begin
			rad_q[0]  <= sq_x + sq_y;
			rem_q[0]  <= '0;
			root_q[0] <= '0;
		end
	end

	// one result bit per stage
	for (genvar k = 1; k <= N; k++) begin : g_step
		logic [MW-1:0] cand;
		logic [MW-1:0] trial;
		logic          ge;
		assign cand  = {rem_q[k-1][MW-3:0], rad_q[k-1][SW-1:SW-2]};
		assign trial = {1'b0, root_q[k-1], 2'b01};
		assign ge    = cand >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				rad_q[k]  <= {rad_q[k-1][SW-3:0], 2'b00};
				rem_q[k]  <= ge ? (cand - trial) : cand;
				root_q[k] <= {root_q[k-1][RW-2:0], ge};
			end
		end
	end

	// remainder above root means the fraction is over one half
	always_ff @(posedge clk) begin
		if (en) begin
			mag_q <= root_q[N] + RW'(rem_q[N] > MW'(root_q[N]));
		end
	end

	assign mag = mag_q;

endmodule

`default_nettype wire

// ----- src/v2a_div.sv -----
// pipelined restoring divider for one normalize lane: round(u * 2^frac / mag)
// depends on v2a_pkg
`timescale 1ns / 1ps
`default_nettype none

module v2a_div (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [v2a_pkg::ROOT_W-1:0]    mag,
	input  wire logic [v2a_pkg::DATA_W-1:0]    u,
	output logic [v2a_pkg::QUOT_W-1:0]         quot
);

	localparam int RW = v2a_pkg::DREM_W;
	localparam int QW = v2a_pkg::QUOT_W;
	localparam int MW = v2a_pkg::ROOT_W;

	logic [RW-1:0] rem_q [0:QW];
	logic [MW-1:0] dv_q  [0:QW];
	logic [QW-1:0] q_q   [0:QW];

	// dividend with half the divisor added for rounding
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= (RW'(u) << v2a_pkg::FRAC_BITS) + RW'(mag >> 1);
			dv_q[0]  <= mag;
			q_q[0]   <= '0;
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_step
		logic [RW-1:0] shd;
		logic          ge;
		assign shd = RW'(dv_q[k-1]) << (QW - k);
		assign ge  = rem_q[k-1] >= shd;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? (rem_q[k-1] - shd) : rem_q[k-1];
				dv_q[k]  <= dv_q[k-1];
				q_q[k]   <= {q_q[k-1][QW-2:0], ge};
			end
		end
	end

	assign quot = q_q[QW];

endmodule

`default_nettype wire

// ----- src/vector2d_alu_core.sv -----
// top level of the 2d vector alu: input stage, two lanes, sqrt merge, divider lanes
// depends on v2a_pkg, v2a_lane, v2a_sqrt, v2a_div
`timescale 1ns / 1ps
`default_nettype none

// usage
//   input channel: in_valid / in_ready with func, a_x, a_y, b_x, b_y, scale_factor,
//   all vector fields signed q16.16; output channel: out_valid / out_ready with
//   res_x, res_y, magnitude, saturated, zero_length. every item gives one result
//   every operation takes the same path to the output register: input stage,
//   lane stage, square root, normalize divider (fixed-depth pipeline)
//   throughput: one item per cycle while the output is not stalled; the depth is set
//   by the 32-stage square root (one root bit per stage) and the 18-stage normalize
//   divider, one quotient bit per stage, running after it
//   the x and y components go down two identical lanes (add/sub, scale multiplier
//   that also forms the squares, divider); the sqrt stage merges both lanes
//   stall: the whole pipeline holds while the output register holds an item that
//   is not taken; in_ready is low exactly then, so nothing in flight is lost
//   reset: clears every valid bit, so in_ready is high as soon as reset
//   releases; payload registers keep whatever they hold
//   the block keeps no state between items

module vector2d_alu_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [v2a_pkg::FUNC_W-1:0]          func,
	input  wire logic signed [v2a_pkg::DATA_W-1:0]   a_x,
	input  wire logic signed [v2a_pkg::DATA_W-1:0]   a_y,
	input  wire logic signed [v2a_pkg::DATA_W-1:0]   b_x,
	input  wire logic signed [v2a_pkg::DATA_W-1:0]   b_y,
	input  wire logic signed [v2a_pkg::DATA_W-1:0]   scale_factor,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [v2a_pkg::DATA_W-1:0]        res_x,
	output logic signed [v2a_pkg::DATA_W-1:0]        res_y,
	output logic [v2a_pkg::ROOT_W-1:0]               magnitude,
	output logic                                     saturated,
	output logic                                     zero_length
);

	localparam int W  = v2a_pkg::DATA_W;
	localparam int QW = v2a_pkg::QUOT_W;
	localparam int ND = v2a_pkg::META_DEPTH;

	// pipeline advance: only the output register can block
	logic en;

	// input stage
	logic                          valid_s1;
	logic [v2a_pkg::FUNC_W-1:0]    func_s1;
	logic signed [W-1:0]           ax_s1, ay_s1, bx_s1, by_s1, sf_s1;

	// lane stage
	logic                          valid_s2;
	logic [v2a_pkg::FUNC_W-1:0]    func_s2;

	// lane outputs
	logic signed [W-1:0]           lres_x, lres_y;
	logic                          lsat_x, lsat_y;
	logic [v2a_pkg::SQ_W-1:0]      sq_x, sq_y;
	logic                          neg_x, neg_y;
	logic [W-1:0]                  ua_x, ua_y;

	// sideband that travels with the sqrt and divider stages
	v2a_pkg::meta_t                meta_q [0:ND-1];
	logic [ND-1:0]                 meta_vld_q;
	v2a_pkg::meta_t                meta_mag;

	logic [v2a_pkg::ROOT_W-1:0]    sqrt_mag;
	logic [QW-1:0]                 quot_x, quot_y;

	// final selection
	v2a_pkg::meta_t                fin;
	logic signed [W-1:0]           fx, fy;
	logic [v2a_pkg::ROOT_W-1:0]    fmag;
	logic                          fsat, fzl;

	// output register
	logic                          out_valid_q;
	logic signed [W-1:0]           res_x_q, res_y_q;
	logic [v2a_pkg::ROOT_W-1:0]    mag_q;
	logic                          sat_q, zl_q;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			meta_vld_q <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= in_valid;
			valid_s2    <= valid_s1;
			meta_vld_q  <= {meta_vld_q[ND-2:0], valid_s2};
			out_valid_q <= meta_vld_q[ND-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= func;
			ax_s1   <= a_x;
			ay_s1   <= a_y;
			bx_s1   <= b_x;
			by_s1   <= b_y;
			sf_s1   <= scale_factor;
			func_s2 <= func_s1;
		end
	end

	v2a_lane u_lane_x (
		.clk     (clk),
		.en      (en),
		.func_s1 (func_s1),
		.func_s2 (func_s2),
		.a       (ax_s1),
		.b       (bx_s1),
		.sf      (sf_s1),
		.res     (lres_x),
		.sat     (lsat_x),
		.sq      (sq_x),
		.neg     (neg_x),
		.ua      (ua_x)
	);

	v2a_lane u_lane_y (
		.clk     (clk),
		.en      (en),
		.func_s1 (func_s1),
		.func_s2 (func_s2),
		.a       (ay_s1),
		.b       (by_s1),
		.sf      (sf_s1),
		.res     (lres_y),
		.sat     (lsat_y),
		.sq      (sq_y),
		.neg     (neg_y),
		.ua      (ua_y)
	);

	// sum of squares is merged inside the sqrt unit
	v2a_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.sq_x (sq_x),
		.sq_y (sq_y),
		.mag  (sqrt_mag)
	);

	// entry that picks up the finished root as it moves on
	always_comb begin
		meta_mag     = meta_q[v2a_pkg::META_MAG_IDX-1];
		meta_mag.mag = sqrt_mag;
	end

	// sideband shift line; magnitude joins it when the root is done
	always_ff @(posedge clk) begin
		if (en) begin
			meta_q[0].func  <= func_s2;
			meta_q[0].res_x <= lres_x;
			meta_q[0].res_y <= lres_y;
			meta_q[0].sat   <= lsat_x | lsat_y;
			meta_q[0].neg_x <= neg_x;
			meta_q[0].neg_y <= neg_y;
			meta_q[0].ux    <= ua_x;
			meta_q[0].uy    <= ua_y;
			meta_q[0].mag   <= '0;
			for (int i = 1; i < ND; i++) begin
				if (i == v2a_pkg::META_MAG_IDX) begin
					meta_q[i] <= meta_mag;
				end else begin
					meta_q[i] <= meta_q[i-1];
				end
			end
		end
	end

	v2a_div u_div_x (
		.clk  (clk),
		.en   (en),
		.mag  (sqrt_mag),
		.u    (meta_q[v2a_pkg::META_DIV_IDX].ux),
		.quot (quot_x)
	);

	v2a_div u_div_y (
		.clk  (clk),
		.en   (en),
		.mag  (sqrt_mag),
		.u    (meta_q[v2a_pkg::META_DIV_IDX].uy),
		.quot (quot_y)
	);

	assign fin = meta_q[v2a_pkg::META_LAST];

	always_comb begin
		fx   = fin.res_x;
		fy   = fin.res_y;
		fmag = '0;
		fsat = fin.sat;
		fzl  = 1'b0;
		case (fin.func)
			v2a_pkg::FUNC_ADD, v2a_pkg::FUNC_SUB, v2a_pkg::FUNC_SCALE: begin
				fx   = fin.res_x;
				fy   = fin.res_y;
			end
			v2a_pkg::FUNC_LEN: begin
				fx   = '0;
				fy   = '0;
				fmag = fin.mag;
				fsat = 1'b0;
			end
			v2a_pkg::FUNC_NORM: begin
				fmag = fin.mag;
				fsat = 1'b0;
				if (fin.mag == '0) begin
					// zero vector: no direction
					fx  = '0;
					fy  = '0;
					fzl = 1'b1;
				end else begin
					fx = fin.neg_x ? -W'(quot_x) : W'(quot_x);
					fy = fin.neg_y ? -W'(quot_y) : W'(quot_y);
				end
			end
			default: begin
				fx   = '0;
				fy   = '0;
				fsat = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_x_q <= fx;
			res_y_q <= fy;
			mag_q   <= fmag;
			sat_q   <= fsat;
			zl_q    <= fzl;
		end
	end

	assign out_valid   = out_valid_q;
	assign res_x       = res_x_q;
	assign res_y       = res_y_q;
	assign magnitude   = mag_q;
	assign saturated   = sat_q;
	assign zero_length = zl_q;

`ifndef SYNTHESIS
	// a zero-length result carries nothing else
	a_zl_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_length |-> res_x == '0 && res_y == '0 && magnitude == '0)
		else $error("zero_length with nonzero result");

	// clipping only happens on operations that report no magnitude
	a_sat_no_mag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> magnitude == '0 && !zero_length)
		else $error("saturated together with magnitude or zero_length");

	// a stalled output holds the pipeline: nothing may enter
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted while output stalled");
`endif

endmodule

`default_nettype wire

// ----- sim/tb_vector2d_alu_core.sv -----
// self-checking testbench for vector2d_alu_core: random and directed vector items
// depends on v2a_pkg and the vector2d_alu_core rtl
`timescale 1ns / 1ps

module tb_vector2d_alu_core;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 80;
	localparam int DW             = v2a_pkg::DATA_W;
	localparam int FW             = v2a_pkg::FUNC_W;
	localparam int FB             = v2a_pkg::FRAC_BITS;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [FW-1:0] func = '0;
	logic signed [DW-1:0] a_x = '0, a_y = '0, b_x = '0, b_y = '0, scale_factor = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [DW-1:0] res_x, res_y;
	logic [v2a_pkg::ROOT_W-1:0] magnitude;
	logic saturated, zero_length;

	typedef struct packed {
		logic [DW-1:0] rx;
		logic [DW-1:0] ry;
		logic [DW-1:0] mag;
		logic          sat;
		logic          zl;
	} vec_result_t;

	// expected-result store with the vector math predictor
	class vec_scoreboard;
		vec_result_t pending[$];
		int errors = 0;
		int checked = 0;

		function automatic logic signed [DW-1:0] clip(input logic signed [65:0] v,
			inout logic sat);
			logic signed [65:0] hi, lo;
			hi = 66'sd2147483647;
			lo = -66'sd2147483648;
			if (v > hi) begin
				sat = 1'b1;
				return hi[DW-1:0];
			end
			if (v < lo) begin
				sat = 1'b1;
				return lo[DW-1:0];
			end
			return v[DW-1:0];
		endfunction

		function automatic logic [63:0] isqrt_round(input logic [63:0] s);
			logic [63:0] r, rem;
			r = 0;
			for (int b = 31; b >= 0; b--) begin
				if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= s)
					r = r | (64'd1 << b);
			end
			rem = s - r * r;
			if (rem > r)
				r = r + 1;
			return r;
		endfunction

		function automatic logic signed [DW-1:0] unit_comp(input logic signed [DW-1:0] c,
			input logic [63:0] mag);
			logic [63:0] u, q;
			u = c < 0 ? 64'(-64'(c)) : 64'(c);
			q = ((u << FB) + (mag >> 1)) / mag;
			return c < 0 ? DW'(-q) : DW'(q);
		endfunction

		function void note_item(input logic [FW-1:0] f, input logic signed [DW-1:0] ax,
			input logic signed [DW-1:0] ay, input logic signed [DW-1:0] bx,
			input logic signed [DW-1:0] by, input logic signed [DW-1:0] sf);
			vec_result_t e;
			logic signed [65:0] px, py;
			logic [63:0] ux, uy, m;
			e = '0;
			case (f)
				v2a_pkg::FUNC_ADD: begin
					e.rx = clip(66'(ax) + 66'(bx), e.sat);
					e.ry = clip(66'(ay) + 66'(by), e.sat);
				end
				v2a_pkg::FUNC_SUB: begin
					e.rx = clip(66'(ax) - 66'(bx), e.sat);
					e.ry = clip(66'(ay) - 66'(by), e.sat);
				end
				v2a_pkg::FUNC_SCALE: begin
					// round half up then arithmetic shift
					px = (66'(ax) * 66'(sf) + (66'sd1 <<< (FB - 1))) >>> FB;
					py = (66'(ay) * 66'(sf) + (66'sd1 <<< (FB - 1))) >>> FB;
					e.rx = clip(px, e.sat);
					e.ry = clip(py, e.sat);
				end
				v2a_pkg::FUNC_LEN, v2a_pkg::FUNC_NORM: begin
					ux = ax < 0 ? 64'(-64'(ax)) : 64'(ax);
					uy = ay < 0 ? 64'(-64'(ay)) : 64'(ay);
					m = isqrt_round(ux * ux + uy * uy);
					e.mag = m[DW-1:0];
					if (f == v2a_pkg::FUNC_NORM) begin
						if (m == 0)
							e.zl = 1'b1;
						else begin
							e.rx = unit_comp(ax, m);
							e.ry = unit_comp(ay, m);
						end
					end
				end
				default: ;
			endcase
			pending.push_back(e);
		endfunction

		function void check_result(input vec_result_t got);
			vec_result_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (got.rx !== e.rx) begin
				$display("%0t: res_x exp %h got %h", $time, e.rx, got.rx);
				errors++;
			end
			if (got.ry !== e.ry) begin
				$display("%0t: res_y exp %h got %h", $time, e.ry, got.ry);
				errors++;
			end
			if (got.mag !== e.mag) begin
				$display("%0t: magnitude exp %h got %h", $time, e.mag, got.mag);
				errors++;
			end
			if (got.sat !== e.sat) begin
				$display("%0t: saturated exp %b got %b", $time, e.sat, got.sat);
				errors++;
			end
			if (got.zl !== e.zl) begin
				$display("%0t: zero_length exp %b got %b", $time, e.zl, got.zl);
				errors++;
			end
		endfunction
	endclass

	vec_scoreboard board;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit recv_hold = 0;
	int idle_cycles = 0;
	int items_sent = 0;
	bit finished = 0;

	always #4 clk = ~clk;

	vector2d_alu_core dut (
		.clk, .arst_n, .in_valid, .in_ready, .func, .a_x, .a_y, .b_x, .b_y, .scale_factor,
		.out_valid, .out_ready, .res_x, .res_y, .magnitude, .saturated, .zero_length
	);

	// note accepted items and check results at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				board.note_item(func, a_x, a_y, b_x, b_y, scale_factor);
			if (out_valid && out_ready)
				board.check_result({res_x, res_y, magnitude, saturated, zero_length});
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver: random stalls, or a long forced hold-off
	always @(negedge clk) begin
		if (recv_hold)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// watchdog
	always @(posedge clk) begin
		if (!finished && idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", idle_cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// present one item and hold it until accepted
	task automatic send_item(input logic [FW-1:0] f, input logic [DW-1:0] ax,
		input logic [DW-1:0] ay, input logic [DW-1:0] bx,
		input logic [DW-1:0] by, input logic [DW-1:0] sf);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		a_x <= ax;
		a_y <= ay;
		b_x <= bx;
		b_y <= by;
		scale_factor <= sf;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic go_quiet();
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [DW-1:0] rand_word();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(3) :
				32'h80000000 + $urandom_range(3);
			2: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
			3: return $urandom_range(8) << FB;
			4: return -($urandom_range(8) << FB);
			default: return 32'($signed(18'($urandom)));
		endcase
	endfunction

	task automatic send_random(input int n);
		logic [FW-1:0] f;
		for (int i = 0; i < n; i++) begin
			// codes outside the defined set show up now and then
			f = ($urandom_range(19) == 0) ? FW'($urandom_range(7, 5)) :
				FW'($urandom_range(4));
			send_item(f, rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
		end
	endtask

	task automatic wait_drained();
		go_quiet();
		while (board.pending.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		localparam logic [DW-1:0] MAXW = 32'h7fffffff;
		localparam logic [DW-1:0] MINW = 32'h80000000;
		localparam logic [DW-1:0] ONE = 32'h00010000;
		int hold_len;
		board = new();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: extremes, every operation, saturation, zero vector, unknown codes
		send_item(v2a_pkg::FUNC_ADD, MAXW, MINW, 1, -1, 0);
		send_item(v2a_pkg::FUNC_ADD, MINW, MAXW, MINW, MAXW, 0);
		send_item(v2a_pkg::FUNC_ADD, ONE, -ONE, ONE, ONE, 0);
		send_item(v2a_pkg::FUNC_SUB, MINW, MAXW, 1, -1, 0);
		send_item(v2a_pkg::FUNC_SUB, MAXW, MINW, MINW, MAXW, 0);
		send_item(v2a_pkg::FUNC_SUB, 0, 0, 0, 0, 0);
		send_item(v2a_pkg::FUNC_SCALE, MAXW, MINW, 0, 0, MAXW);
		send_item(v2a_pkg::FUNC_SCALE, MINW, MINW, 0, 0, MINW);
		send_item(v2a_pkg::FUNC_SCALE, ONE, -ONE, 0, 0, 32'h00008000);
		send_item(v2a_pkg::FUNC_SCALE, 1, -1, 0, 0, 32'h00008000);
		send_item(v2a_pkg::FUNC_SCALE, 3, -3, 0, 0, 32'hffff8000);
		send_item(v2a_pkg::FUNC_LEN, MINW, MINW, 0, 0, 0);
		send_item(v2a_pkg::FUNC_LEN, MAXW, MAXW, 0, 0, 0);
		send_item(v2a_pkg::FUNC_LEN, 3 * ONE, 4 * ONE, 0, 0, 0);
		send_item(v2a_pkg::FUNC_LEN, 0, 0, 0, 0, 0);
		send_item(v2a_pkg::FUNC_NORM, 0, 0, MAXW, MINW, MAXW);
		send_item(v2a_pkg::FUNC_NORM, MINW, MINW, 0, 0, 0);
		send_item(v2a_pkg::FUNC_NORM, 1, 0, 0, 0, 0);
		send_item(v2a_pkg::FUNC_NORM, -3 * ONE, 4 * ONE, 0, 0, 0);
		send_item(v2a_pkg::FUNC_NORM, MAXW, 1, 0, 0, 0);
		send_item(3'd5, MAXW, MAXW, MAXW, MAXW, MAXW);
		send_item(3'd6, MINW, MINW, MINW, MINW, MINW);
		send_item(3'd7, 32'hffffffff, 1, 2, 3, 4);

		// sender pauses until the pipeline has emptied
		wait_drained();

		send_idle_pct = 8;
		recv_idle_pct = 64;
		send_random(480);

		// long receiver hold-off so the pipeline backs up into the input
		recv_hold = 1;
		fork
			begin
				hold_len = 200;
				repeat (hold_len) @(negedge clk);
				recv_hold = 0;
			end
			send_random(100);
		join

		send_idle_pct = 64;
		recv_idle_pct = 8;
		send_random(420);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random(420);

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		finished = 1;
		$display("covered %0d items over all five operations and unknown codes,",
			items_sent);
		$display("with saturation, zero-vector normalize and sender/receiver stalls");
		if (board.errors == 0 && board.pending.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/v2a_pkg.sv
src/v2a_lane.sv
src/v2a_sqrt.sv
src/v2a_div.sv
src/vector2d_alu_core.sv
sim/tb_vector2d_alu_core.sv
